/* src/twao_pkg.sv */
// Package for the two-wheel arc odometry block: word types, fixed-point
// constants and the CORDIC arctangent table. No dependencies.
package twao_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_OFFSET  = 2'd1;

    // datapath widths that do not move with the fraction width
    localparam int DELTA_W  = 33;   // tracker and heading deltas
    localparam int MA_W     = 36;   // multiplier operand A
    localparam int MB_W     = 28;   // multiplier operand B
    localparam int P_W      = MA_W + MB_W;
    localparam int ZW       = 35;   // CORDIC angle register, Q30
    localparam int XW       = 34;   // CORDIC x/y registers, Q30
    localparam int AT_IDX_W = 5;

    localparam logic signed [MB_W-1:0] DEG2RAD_Q32 = 28'sd74961321;
    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518853;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] horiz_tracker;
        logic signed [31:0] vert_tracker;
        logic signed [31:0] heading;
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_out_word;

    // truncated atan(2^-i) in Q30
    function automatic logic signed [ZW-1:0] atan_q30(input logic [AT_IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 35'sh3243F6A8;
            5'd1:    v = 35'sh1DAC6705;
            5'd2:    v = 35'sh0FADBAFC;
            5'd3:    v = 35'sh07F56EA6;
            5'd4:    v = 35'sh03FEAB76;
            5'd5:    v = 35'sh01FFD55B;
            5'd6:    v = 35'sh00FFFAAA;
            5'd7:    v = 35'sh007FFF55;
            5'd8:    v = 35'sh003FFFEA;
            5'd9:    v = 35'sh001FFFFD;
            5'd10:   v = 35'sh000FFFFF;
            5'd11:   v = 35'sh0007FFFF;
            5'd12:   v = 35'sh0003FFFF;
            5'd13:   v = 35'sh0001FFFF;
            5'd14:   v = 35'sh0000FFFF;
            5'd15:   v = 35'sh00007FFF;
            5'd16:   v = 35'sh00003FFF;
            5'd17:   v = 35'sh00001FFF;
            5'd18:   v = 35'sh00000FFF;
            5'd19:   v = 35'sh000007FF;
            5'd20:   v = 35'sh000003FF;
            5'd21:   v = 35'sh000001FF;
            5'd22:   v = 35'sh000000FF;
            5'd23:   v = 35'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* src/twao_mul.sv */
// Shared signed multiplier with registered product.
// Depends on twao_pkg for operand widths.
module twao_mul (
    input  logic                                i_clk,
    input  logic signed [twao_pkg::MA_W-1:0]    i_a,
    input  logic signed [twao_pkg::MB_W-1:0]    i_b,
    output logic signed [twao_pkg::P_W-1:0]     o_p
);

    logic signed [twao_pkg::P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= twao_pkg::P_W'(i_a) * twao_pkg::P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* src/twao_div.sv */
// Iterative restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero and saturated to 32-bit signed. Depends on twao_pkg.
module twao_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [twao_pkg::DELTA_W-1:0]     i_num,
    input  logic signed [twao_pkg::DELTA_W-1:0]     i_den,
    output logic signed [31:0]                      o_quot,
    output logic                                    o_busy
);

    localparam int NW = twao_pkg::DELTA_W + FRAC_BITS;
    localparam int DW = twao_pkg::DELTA_W + 32;

    typedef enum logic [1:0] {S_IDLE, S_CHK, S_RUN, S_FIN} t_state;

    t_state                         r_state;
    logic [NW-1:0]                  r_rem;
    logic [DW-1:0]                  r_d;
    logic [31:0]                    r_q;
    logic [4:0]                     r_cnt;
    logic                           r_neg;
    logic                           r_sat;
    logic signed [31:0]             r_quot;
    logic [twao_pkg::DELTA_W-1:0]   num_mag;
    logic [twao_pkg::DELTA_W-1:0]   den_mag;
    logic                           ge;

    assign num_mag = i_num[twao_pkg::DELTA_W-1] ? twao_pkg::DELTA_W'(-i_num) : i_num;
    assign den_mag = i_den[twao_pkg::DELTA_W-1] ? twao_pkg::DELTA_W'(-i_den) : i_den;
    assign ge      = DW'(r_rem) >= r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem   <= {num_mag, FRAC_BITS'(0)};
                        r_d     <= {den_mag, 32'd0};
                        r_neg   <= i_num[twao_pkg::DELTA_W-1] ^ i_den[twao_pkg::DELTA_W-1];
                        r_q     <= '0;
                        r_cnt   <= 5'd31;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // quotient of 2^32 or more saturates regardless of sign
                    r_sat   <= ge;
                    r_d     <= r_d >> 1;
                    r_state <= ge ? S_FIN : S_RUN;
                end
                S_RUN: begin
                    if (ge) begin
                        r_rem <= r_rem - NW'(r_d);
                    end
                    r_q   <= {r_q[30:0], ge};
                    r_d   <= r_d >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_sat) begin
                        r_quot <= r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else if (!r_neg) begin
                        r_quot <= (r_q > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_q);
                    end else begin
                        r_quot <= (r_q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-r_q);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_quot = r_quot;
    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/twao_cordic.sv */
// Iterative sine/cosine: modulo-2pi reduction by shift and subtract, fold to
// [-pi/2, pi/2], then rotation-mode CORDIC in Q30. Depends on twao_pkg.
module twao_cordic #(
    parameter int FRAC_BITS = 16,
    parameter int STEPS     = 16,
    parameter int ANG_W     = 44
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [ANG_W-1:0]     i_angle,
    output logic signed [FRAC_BITS+1:0] o_sin,
    output logic signed [FRAC_BITS+1:0] o_cos,
    output logic                        o_busy
);

    localparam int ZW        = twao_pkg::ZW;
    localparam int XW        = twao_pkg::XW;
    localparam int SC_W      = FRAC_BITS + 2;
    localparam int MOD_STEPS = ANG_W - 32;
    localparam int MAX_CNT   = (MOD_STEPS > STEPS) ? MOD_STEPS : STEPS;
    localparam int CNT_W     = $clog2(MAX_CNT + 1);
    localparam int RND_SH    = 30 - FRAC_BITS;

    typedef enum logic [2:0] {S_IDLE, S_MOD, S_SIGN, S_FOLD1, S_FOLD2, S_ROT, S_OUT} t_state;

    t_state                 r_state;
    logic [ANG_W-1:0]       r_m;
    logic [ANG_W-1:0]       r_d;
    logic                   r_neg;
    logic                   r_flip;
    logic [CNT_W-1:0]       r_k;
    logic signed [ZW-1:0]   r_z;
    logic signed [XW-1:0]   r_x;
    logic signed [XW-1:0]   r_y;
    logic signed [SC_W-1:0] r_sin;
    logic signed [SC_W-1:0] r_cos;
    logic signed [XW-1:0]   sh_x;
    logic signed [XW-1:0]   sh_y;
    logic signed [ZW-1:0]   at;
    logic signed [XW-1:0]   xf;
    logic signed [XW-1:0]   yf;
    logic signed [XW-1:0]   xr;
    logic signed [XW-1:0]   yr;

    assign sh_x = r_x >>> r_k;
    assign sh_y = r_y >>> r_k;
    assign at   = twao_pkg::atan_q30(twao_pkg::AT_IDX_W'(r_k));
    assign xf   = r_flip ? -r_x : r_x;
    assign yf   = r_flip ? -r_y : r_y;
    assign xr   = xf + (XW'(1) <<< (RND_SH - 1));
    assign yr   = yf + (XW'(1) <<< (RND_SH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m     <= i_angle[ANG_W-1] ? ANG_W'(-i_angle) : i_angle;
                        r_neg   <= i_angle[ANG_W-1];
                        r_d     <= ANG_W'(twao_pkg::TWO_PI_Q30) << (MOD_STEPS - 1);
                        r_k     <= CNT_W'(MOD_STEPS - 1);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_m >= r_d) begin
                        r_m <= r_m - r_d;
                    end
                    r_d <= r_d >> 1;
                    r_k <= r_k - CNT_W'(1);
                    if (r_k == '0) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    // remainder takes the sign of the angle
                    r_z     <= r_neg ? -ZW'(r_m) : ZW'(r_m);
                    r_state <= S_FOLD1;
                end
                S_FOLD1: begin
                    if (r_z > twao_pkg::PI_Q30) begin
                        r_z <= r_z - twao_pkg::TWO_PI_Q30;
                    end else if (r_z < -twao_pkg::PI_Q30) begin
                        r_z <= r_z + twao_pkg::TWO_PI_Q30;
                    end
                    r_state <= S_FOLD2;
                end
                S_FOLD2: begin
                    r_flip <= 1'b0;
                    if (r_z > twao_pkg::HALF_PI_Q30) begin
                        r_z    <= r_z - twao_pkg::PI_Q30;
                        r_flip <= 1'b1;
                    end else if (r_z < -twao_pkg::HALF_PI_Q30) begin
                        r_z    <= r_z + twao_pkg::PI_Q30;
                        r_flip <= 1'b1;
                    end
                    r_x     <= twao_pkg::GAIN_Q30;
                    r_y     <= '0;
                    r_k     <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - sh_y;
                        r_y <= r_y + sh_x;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + sh_y;
                        r_y <= r_y - sh_x;
                        r_z <= r_z + at;
                    end
                    r_k <= r_k + CNT_W'(1);
                    if (r_k == CNT_W'(STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_cos   <= xr[RND_SH+SC_W-1:RND_SH];
                    r_sin   <= yr[RND_SH+SC_W-1:RND_SH];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/two_wheel_arc_odometry_top.sv */
// Two-wheel arc odometry top level: sequencer around the shared multiplier,
// two dividers and the CORDIC unit. Depends on twao_pkg, twao_mul, twao_div,
// twao_cordic.
//
// Pose tracker for one horizontal and one vertical tracking wheel plus a
// heading reading, all fixed point with FRAC_BITS fraction bits. Each input
// word yields exactly one output word with the new global x and y. A set word
// (cmd = 1) loads the pose and heading and clears the stored tracker values.
// An update word converts the heading to radians, forms the deltas, and when
// the heading moved divides each delta by the heading change (two 32-step
// restoring dividers in parallel, overlapped with the half-angle sine pass),
// then runs a second CORDIC pass for the mid angle and rotates the local move
// with four products on the one multiplier. One CORDIC pass is
// (28 - FRAC_BITS) reduction steps, a sign step, two fold steps,
// CORDIC_STEPS rotations and an output step. The input stays stalled for
// the whole item; a finished word waits in the output register while the
// next item is taken.
// The offset registers are written through the cfg port, always ready;
// write them only while the block is idle.
module two_wheel_arc_odometry_top #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  twao_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output twao_pkg::t_out_word                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [twao_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    localparam int MA_W    = twao_pkg::MA_W;
    localparam int MB_W    = twao_pkg::MB_W;
    localparam int P_W     = twao_pkg::P_W;
    localparam int DELTA_W = twao_pkg::DELTA_W;
    localparam int SC_W    = FRAC_BITS + 2;
    localparam int ANG_W   = 60 - FRAC_BITS;
    localparam int HALF_SH = 29 - FRAC_BITS;
    localparam int MID_SH  = 30 - FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DEG, S_ANG, S_DISP, S_HALF, S_CH1, S_CH2, S_CH3,
        S_MID, S_M1, S_M2, S_M3, S_M4, S_M5, S_EMIT
    } t_state;

    t_state                 r_state;
    twao_pkg::t_in_word     r_in;
    twao_pkg::t_out_word    r_out;
    logic                   r_out_valid;
    logic signed [31:0]     r_off_h;
    logic signed [31:0]     r_off_v;
    logic signed [31:0]     r_gx;
    logic signed [31:0]     r_gy;
    logic signed [31:0]     r_last_h;
    logic signed [31:0]     r_last_v;
    logic signed [31:0]     r_last_head;
    logic signed [31:0]     r_rad;
    logic signed [DELTA_W-1:0] r_dh;
    logic signed [DELTA_W-1:0] r_dv;
    logic signed [DELTA_W-1:0] r_dth;
    logic signed [MA_W-1:0] r_lx;
    logic signed [MA_W-1:0] r_ly;
    logic signed [SC_W-1:0] r_sin_half;
    logic signed [SC_W-1:0] r_sin;
    logic signed [SC_W-1:0] r_cos;
    logic signed [P_W-1:0]  r_acc;

    // shared unit hookup
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p;
    logic                   div_start;
    logic signed [31:0]     div_h_q;
    logic signed [31:0]     div_v_q;
    logic                   div_h_busy;
    logic                   div_v_busy;
    logic                   cor_start;
    logic signed [ANG_W-1:0] cor_angle;
    logic signed [SC_W-1:0] cor_sin;
    logic signed [SC_W-1:0] cor_cos;
    logic                   cor_busy;
    logic                   units_done;

    logic signed [ANG_W-1:0] half_ang;
    logic signed [ANG_W-1:0] mid_ang;
    logic signed [MA_W-1:0]  chord_h;
    logic signed [MA_W-1:0]  chord_v;
    logic signed [P_W-1:0]   sum_x;
    logic signed [P_W-1:0]   sum_y;
    logic                    in_take;
    logic                    out_load;
    logic                    moved;

    assign in_take    = i_in_valid && !o_in_stall;
    assign units_done = !div_h_busy && !div_v_busy && !cor_busy;
    assign moved      = (r_dth != '0);

    // dtheta/2 and prev + dtheta/2, both Q30
    assign half_ang = ANG_W'(r_dth) <<< HALF_SH;
    assign mid_ang  = (ANG_W'(r_last_head) <<< MID_SH) + half_ang;

    // 2 * (delta/dtheta + offset)
    assign chord_h = (MA_W'(div_h_q) + MA_W'(r_off_h)) <<< 1;
    assign chord_v = (MA_W'(div_v_q) + MA_W'(r_off_v)) <<< 1;

    assign sum_x = r_acc + mul_p;
    assign sum_y = r_acc - mul_p;

    assign div_start = (r_state == S_DISP) && !r_in.cmd && moved;
    assign cor_start = ((r_state == S_DISP) && !r_in.cmd) ||
                       ((r_state == S_HALF) && units_done);
    assign cor_angle = ((r_state == S_DISP) && moved) ? half_ang : mid_ang;

    assign out_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DEG: begin
                mul_a = MA_W'(r_in.heading);
                mul_b = twao_pkg::DEG2RAD_Q32;
            end
            S_CH1: begin
                mul_a = chord_h;
                mul_b = MB_W'(r_sin_half);
            end
            S_CH2: begin
                mul_a = chord_v;
                mul_b = MB_W'(r_sin_half);
            end
            S_M1: begin
                mul_a = r_lx;
                mul_b = MB_W'(r_cos);
            end
            S_M2: begin
                mul_a = r_ly;
                mul_b = MB_W'(r_sin);
            end
            S_M3: begin
                mul_a = r_ly;
                mul_b = MB_W'(r_cos);
            end
            S_M4: begin
                mul_a = r_lx;
                mul_b = MB_W'(r_sin);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    twao_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    twao_div #(.FRAC_BITS(FRAC_BITS)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_dh),
        .i_den   (r_dth),
        .o_quot  (div_h_q),
        .o_busy  (div_h_busy)
    );

    twao_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_dv),
        .i_den   (r_dth),
        .o_quot  (div_v_q),
        .o_busy  (div_v_busy)
    );

    twao_cordic #(
        .FRAC_BITS (FRAC_BITS),
        .STEPS     (CORDIC_STEPS),
        .ANG_W     (ANG_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos),
        .o_busy  (cor_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_off_h     <= '0;
            r_off_v     <= '0;
            r_gx        <= '0;
            r_gy        <= '0;
            r_last_h    <= '0;
            r_last_v    <= '0;
            r_last_head <= '0;
        end else begin
            // config port: unknown indexes drop the word
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    twao_pkg::CFG_HORIZ_OFFSET: r_off_h <= $signed(i_cfg_data);
                    twao_pkg::CFG_VERT_OFFSET:  r_off_v <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out.pos_x <= r_gx;
                r_out.pos_y <= r_gy;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_in    <= i_in_data;
                        r_state <= S_DEG;
                    end
                end
                S_DEG: r_state <= S_ANG;
                S_ANG: begin
                    // radians = floor(deg * pi/180 in Q32 / 2^32)
                    r_rad   <= mul_p[P_W-1:P_W-32];
                    r_dh    <= DELTA_W'(r_in.horiz_tracker) - DELTA_W'(r_last_h);
                    r_dv    <= DELTA_W'(r_in.vert_tracker) - DELTA_W'(r_last_v);
                    r_dth   <= DELTA_W'($signed(mul_p[P_W-1:P_W-32])) -
                               DELTA_W'(r_last_head);
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    if (r_in.cmd) begin
                        r_gx        <= r_in.set_x;
                        r_gy        <= r_in.set_y;
                        r_last_h    <= '0;
                        r_last_v    <= '0;
                        r_last_head <= r_rad;
                        r_state     <= S_EMIT;
                    end else if (moved) begin
                        r_state <= S_HALF;
                    end else begin
                        // straight move: local vector is the raw deltas
                        r_lx    <= MA_W'(r_dh);
                        r_ly    <= MA_W'(r_dv);
                        r_state <= S_MID;
                    end
                end
                S_HALF: begin
                    if (units_done) begin
                        r_sin_half <= cor_sin;
                        r_state    <= S_CH1;
                    end
                end
                S_CH1: r_state <= S_CH2;
                S_CH2: begin
                    r_lx    <= mul_p[FRAC_BITS+MA_W-1:FRAC_BITS];
                    r_state <= S_CH3;
                end
                S_CH3: begin
                    r_ly    <= mul_p[FRAC_BITS+MA_W-1:FRAC_BITS];
                    r_state <= S_MID;
                end
                S_MID: begin
                    if (!cor_busy) begin
                        r_sin   <= cor_sin;
                        r_cos   <= cor_cos;
                        r_state <= S_M1;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_acc   <= mul_p;
                    r_state <= S_M3;
                end
                S_M3: begin
                    // pose wraps mod 2^32, so only the low bits matter
                    r_gx    <= r_gx + sum_x[FRAC_BITS+31:FRAC_BITS];
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_acc   <= mul_p;
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_gy        <= r_gy + sum_y[FRAC_BITS+31:FRAC_BITS];
                    r_last_h    <= r_in.horiz_tracker;
                    r_last_v    <= r_in.vert_tracker;
                    r_last_head <= r_rad;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // a taken word locks the input until its result is queued
    a_take_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after a word was taken");

    // no unit may still run once the sequencer is back in idle
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> units_done)
        else $error("arithmetic unit busy while sequencer idle");

    // output words only come from the emit step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("output word raised outside the emit step");
`endif

endmodule
